// ----- sv/mpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types and codes for the media presentation clock.
// ----------------------------------------------------------------------------
package mpc_pkg;

   localparam int TimeBits = 48;

   // event codes
   localparam logic [3:0] MODE_QUERY      = 4'd0;
   localparam logic [3:0] MODE_AUDIO_RPT  = 4'd1;
   localparam logic [3:0] MODE_VIDEO_RPT  = 4'd2;
   localparam logic [3:0] MODE_PAUSE      = 4'd3;
   localparam logic [3:0] MODE_RESUME     = 4'd4;
   localparam logic [3:0] MODE_SEEK       = 4'd5;
   localparam logic [3:0] MODE_SET_MASTER = 4'd6;
   localparam logic [3:0] MODE_AUDIO_END  = 4'd7;
   localparam logic [3:0] MODE_RESET      = 4'd8;

   // sync master codes
   localparam logic [1:0] SYNC_EXTERNAL = 2'd0;
   localparam logic [1:0] SYNC_AUDIO    = 2'd1;
   localparam logic [1:0] SYNC_VIDEO    = 2'd2;
   localparam logic [1:0] SYNC_NONE     = 2'd3;

   typedef struct packed {
      logic [3:0]                 mode;
      logic [TimeBits-1:0]        sys_ms;
      logic signed [TimeBits-1:0] pts_ms;
      logic [1:0]                 sync_sel;
   } req_type;

   typedef struct packed {
      logic signed [TimeBits-1:0] now_ms;
      logic signed [TimeBits-1:0] age_ms;
      logic                       age_valid;
      logic                       is_paused;
      logic [1:0]                 master_sel;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                 master;
      logic signed [TimeBits-1:0] anchor_media;
      logic [TimeBits-1:0]        anchor_sys;
      logic                       started;
      logic [TimeBits-1:0]        last_report_sys;
      logic                       report_seen;
      logic                       paused;
      logic signed [TimeBits-1:0] frozen_media;
   } clk_state_type;

   localparam clk_state_type STATE_RESET = '{
      master:          SYNC_EXTERNAL,
      anchor_media:    '0,
      anchor_sys:      '0,
      started:         1'b0,
      last_report_sys: '0,
      report_seen:     1'b0,
      paused:          1'b0,
      frozen_media:    '0
   };

endpackage

// ----- sv/media_presentation_clock.sv -----
// ----------------------------------------------------------------------------
// media_presentation_clock
// Anchor-based presentation clock with pause, seek and sync master switch.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Beat
// req      in   req_valid/req_stall  req_type: mode, sys_ms, pts_ms, sync_sel
// rsp      out  rsp_valid/rsp_stall  rsp_type: now_ms, age_ms, status
//
// One beat per cycle sustained while rsp_stall stays low; the edge that accepts a
// beat loads the input register, and the edge that advances it loads the result
// register (event logic plus the two saturating adds; clock state updates there
// too), so a result passes the input register and then the result register.
// Reset clears the clock state and both pipeline valids.
// A stalled result holds the input register; req_stall rises only then.
// ----------------------------------------------------------------------------
module media_presentation_clock
   import mpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type rsp_next;
   logic    advance;
   logic    req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   mpc_state u_state (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req      (in_data_ff),
      .rsp_next (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall without a held item");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced beat did not reach the result register");

   a_no_age_when_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.age_valid) |-> (rsp_data.age_ms == '0))
      else $error("age reported without a report");

   a_seek_result: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.mode == MODE_SEEK)
         |=> (!rsp_data.age_valid && rsp_data.now_ms == $past(in_data_ff.pts_ms)))
      else $error("seek result mismatch");

endmodule

// ----- sv/mpc_sat_diff.sv -----
// ----------------------------------------------------------------------------
// mpc_sat_diff
// Saturating base + (x - y): signed base, unsigned x and y.
// ----------------------------------------------------------------------------
module mpc_sat_diff
   import mpc_pkg::*;
(
   input  logic signed [TimeBits-1:0] base,
   input  logic [TimeBits-1:0]        x,
   input  logic [TimeBits-1:0]        y,
   output logic signed [TimeBits-1:0] sum
);

   localparam logic signed [TimeBits-1:0] SatMax = {1'b0, {(TimeBits-1){1'b1}}};
   localparam logic signed [TimeBits-1:0] SatMin = {1'b1, {(TimeBits-1){1'b0}}};

   // two guard bits cover |base| <= 2^(N-1) plus |x - y| < 2^N
   logic signed [TimeBits+1:0] wide;
   logic [2:0]                 top;

   always_comb begin
      wide = {{2{base[TimeBits-1]}}, base}
             + ($signed({2'b00, x}) - $signed({2'b00, y}));
      top  = wide[TimeBits+1:TimeBits-1];
      if (top == 3'b000 || top == 3'b111) begin
         sum = wide[TimeBits-1:0];
      end else if (wide[TimeBits+1]) begin
         sum = SatMin;
      end else begin
         sum = SatMax;
      end
   end

endmodule

// ----- sv/mpc_state.sv -----
// ----------------------------------------------------------------------------
// mpc_state
// Clock state registers, event decode and result computation for one beat.
// ----------------------------------------------------------------------------
module mpc_state
   import mpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type req,
   output rsp_type rsp_next
);

   clk_state_type state_ff;
   clk_state_type state_in;

   logic signed [TimeBits-1:0] run_ms;
   logic signed [TimeBits-1:0] age_raw;
   logic signed [TimeBits-1:0] cur_ms;
   logic signed [TimeBits-1:0] now_ms;
   logic                       is_report;

   mpc_sat_diff u_run (
      .base (state_ff.anchor_media),
      .x    (req.sys_ms),
      .y    (state_ff.anchor_sys),
      .sum  (run_ms)
   );

   mpc_sat_diff u_age (
      .base ('0),
      .x    (req.sys_ms),
      .y    (state_ff.last_report_sys),
      .sum  (age_raw)
   );

   // reading before the event is applied
   always_comb begin
      if (state_ff.paused) begin
         cur_ms = state_ff.frozen_media;
      end else if (!state_ff.started) begin
         cur_ms = state_ff.anchor_media;
      end else begin
         cur_ms = run_ms;
      end
   end

   // after any re-anchor the reading equals the new anchor, so the result
   // is the pre-event reading except where pts or reset replaces it
   always_comb begin
      state_in  = state_ff;
      now_ms    = cur_ms;
      is_report = 1'b0;
      unique case (req.mode)
         MODE_AUDIO_RPT, MODE_VIDEO_RPT: begin
            is_report                = 1'b1;
            state_in.last_report_sys = req.sys_ms;
            state_in.report_seen     = 1'b1;
            if (state_ff.master == req.mode[1:0]) begin
               state_in.anchor_media = req.pts_ms;
               state_in.anchor_sys   = req.sys_ms;
               state_in.started      = 1'b1;
               if (state_ff.paused) begin
                  state_in.frozen_media = req.pts_ms;
               end
               now_ms = req.pts_ms;
            end
         end
         MODE_PAUSE: begin
            if (!state_ff.paused) begin
               state_in.frozen_media = cur_ms;
               state_in.paused       = 1'b1;
            end
         end
         MODE_RESUME: begin
            if (state_ff.paused) begin
               state_in.anchor_media = state_ff.frozen_media;
               state_in.anchor_sys   = req.sys_ms;
               state_in.started      = 1'b1;
               state_in.paused       = 1'b0;
            end
         end
         MODE_SEEK: begin
            state_in.anchor_media    = req.pts_ms;
            state_in.anchor_sys      = req.sys_ms;
            state_in.started         = 1'b1;
            if (state_ff.paused) begin
               state_in.frozen_media = req.pts_ms;
            end
            state_in.report_seen     = 1'b0;
            state_in.last_report_sys = '0;
            now_ms                   = req.pts_ms;
         end
         MODE_SET_MASTER: begin
            if (req.sync_sel != SYNC_NONE && req.sync_sel != state_ff.master) begin
               state_in.master       = req.sync_sel;
               state_in.anchor_media = cur_ms;
               if (state_ff.started) begin
                  state_in.anchor_sys = req.sys_ms;
                  if (state_ff.paused) begin
                     state_in.frozen_media = cur_ms;
                  end
               end
            end
         end
         MODE_AUDIO_END: begin
            if (state_ff.master == SYNC_AUDIO) begin
               state_in.master       = SYNC_EXTERNAL;
               state_in.anchor_media = cur_ms;
               state_in.anchor_sys   = req.sys_ms;
               state_in.started      = 1'b1;
               if (state_ff.paused) begin
                  state_in.frozen_media = cur_ms;
               end
            end
         end
         MODE_RESET: begin
            state_in = STATE_RESET;
            now_ms   = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_next.now_ms     = now_ms;
      rsp_next.age_valid  = state_in.report_seen;
      rsp_next.age_ms     = (state_in.report_seen && !is_report) ? age_raw : '0;
      rsp_next.is_paused  = state_in.paused;
      rsp_next.master_sel = state_in.master;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

endmodule
